// ===== sv/assert_macros.svh =====
// Shared assertion macros; each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BTA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define BTA_ASSERT_NEVER(label, cond, msg) \
  `BTA_ASSERT(label, !(cond), msg)

`endif

// ===== sv/bta_pkg.sv =====
package bta_pkg;

  localparam int ANGLE_STEPS = 24;
  localparam int TABLE_LEN   = 32;
  // depth of the cross-product class delay line that lines it up with the angle path
  localparam int CLASS_DLY   = ANGLE_STEPS - 6;
  // accept edge to result edge
  localparam int LATENCY     = ANGLE_STEPS + 3;

  localparam logic signed [29:0] DEG_90  = 30'sd94371840;
  localparam logic signed [29:0] DEG_180 = 30'sd188743680;
  localparam logic signed [29:0] DEG_360 = 30'sd377487360;

  localparam logic [26:0] ATAN_TABLE [TABLE_LEN] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121, 27'd3750058, 27'd1876857,
    27'd938658, 27'd469357, 27'd234682, 27'd117342, 27'd58671, 27'd29335,
    27'd14668, 27'd7334, 27'd3667, 27'd1833, 27'd917, 27'd458, 27'd229, 27'd115,
    27'd57, 27'd29, 27'd14, 27'd7, 27'd4, 27'd2, 27'd1, 27'd0, 27'd0, 27'd0,
    27'd0, 27'd0
  };

  // axis-aligned directions bypass the rotator
  typedef enum logic [2:0] {
    DIR_NONE,
    DIR_ZERO,
    DIR_HALF,
    DIR_UP,
    DIR_DOWN
  } dir_t;

  typedef enum logic [2:0] {
    CL_ZERO,
    CL_RAW,
    CL_WRAP,
    CL_CMP,
    CL_CUSP,
    CL_LOOP
  } cls_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [29:0] z;
    dir_t               code;
  } vec_t;

  typedef struct packed {
    logic signed [13:0] e1x;
    logic signed [13:0] e1y;
    logic signed [13:0] e2x;
    logic signed [13:0] e2y;
    logic signed [13:0] e3x;
    logic signed [13:0] e3y;
  } idiff_t;

endpackage

// ===== sv/bezier_turning_angle.sv =====
// Net turn of a cubic Bezier segment. Pulse start with the four control
// points (signed 13.16 fixed point); after one front stage, one stage per
// rotation step (24 rotation steps) and two finishing stages, done is high
// for one cycle with turn_angle (whole degrees times 2^20) and cusp. A new
// item is taken every cycle; busy is high only during reset. Results cannot
// be held off, so capture them when done is high.
module bezier_turning_angle (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [28:0] p0_x,
  input  logic signed [28:0] p0_y,
  input  logic signed [28:0] p1_x,
  input  logic signed [28:0] p1_y,
  input  logic signed [28:0] p2_x,
  input  logic signed [28:0] p2_y,
  input  logic signed [28:0] p3_x,
  input  logic signed [28:0] p3_y,
  output logic               done,
  output logic signed [29:0] turn_angle,
  output logic               cusp
);
  import bta_pkg::*;

  logic               f_vld;
  vec_t               v_in, v_out;
  idiff_t             idiff;
  logic               ci_vld, co_vld;
  logic signed [29:0] zi, zo;
  dir_t               ci_code, co_code;
  cls_t               cls;

  // drop items offered while reset is held
  assign busy = rst;

  // pick the entry/exit vectors and integer-part differences
  bta_front u_front (
    .clk    (clk),
    .rst    (rst),
    .vld_in (start && !busy),
    .p0_x   (p0_x),
    .p0_y   (p0_y),
    .p1_x   (p1_x),
    .p1_y   (p1_y),
    .p2_x   (p2_x),
    .p2_y   (p2_y),
    .p3_x   (p3_x),
    .p3_y   (p3_y),
    .vld    (f_vld),
    .v_in   (v_in),
    .v_out  (v_out),
    .idiff  (idiff)
  );

  // entry direction angle
  bta_cordic u_cordic_in (
    .clk      (clk),
    .rst      (rst),
    .vld_in   (f_vld),
    .v        (v_in),
    .vld_out  (ci_vld),
    .z_out    (zi),
    .code_out (ci_code)
  );

  // exit direction angle; its valid mirrors the entry one
  bta_cordic u_cordic_out (
    .clk      (clk),
    .rst      (rst),
    .vld_in   (f_vld),
    .v        (v_out),
    .vld_out  (co_vld),
    .z_out    (zo),
    .code_out (co_code)
  );

  // inflection classification, delayed to meet the angles
  bta_cross u_cross (
    .clk   (clk),
    .idiff (idiff),
    .cls   (cls)
  );

  // whole degrees, difference and wrap
  bta_turn u_turn (
    .clk        (clk),
    .rst        (rst),
    .vld_in     (ci_vld && co_vld),
    .z_in       (zi),
    .code_in    (ci_code),
    .z_out      (zo),
    .code_out   (co_code),
    .cls        (cls),
    .done       (done),
    .turn_angle (turn_angle),
    .cusp       (cusp)
  );

endmodule

// ===== sv/bta_front.sv =====
module bta_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vld_in,
  input  logic signed [28:0]   p0_x,
  input  logic signed [28:0]   p0_y,
  input  logic signed [28:0]   p1_x,
  input  logic signed [28:0]   p1_y,
  input  logic signed [28:0]   p2_x,
  input  logic signed [28:0]   p2_y,
  input  logic signed [28:0]   p3_x,
  input  logic signed [28:0]   p3_y,
  output logic                 vld,
  output bta_pkg::vec_t        v_in,
  output bta_pkg::vec_t        v_out,
  output bta_pkg::idiff_t      idiff
);
  import bta_pkg::*;

  // classify axis cases and turn into the right half plane
  function automatic vec_t prep(input logic signed [29:0] dx, input logic signed [29:0] dy);
    vec_t v;
    logic signed [31:0] x;
    logic signed [31:0] y;
    x = 32'(dx);
    y = 32'(dy);
    v.x = x;
    v.y = y;
    v.z = '0;
    v.code = DIR_NONE;
    if (dy == 0) begin
      v.code = (dx < 0) ? DIR_HALF : DIR_ZERO;
    end else if (dx == 0) begin
      v.code = (dy > 0) ? DIR_UP : DIR_DOWN;
    end else if (x < 0) begin
      if (y > 0) begin
        v.x = y;
        v.y = -x;
        v.z = DEG_90;
      end else begin
        v.x = -y;
        v.y = x;
        v.z = -DEG_90;
      end
    end
    return v;
  endfunction

  // integer part, truncating toward zero
  function automatic logic signed [13:0] ipart(input logic signed [28:0] p);
    logic signed [29:0] t;
    t = 30'(p) + ((p < 0) ? 30'sd65535 : 30'sd0);
    return 14'($signed(t[28:16]));
  endfunction

  logic signed [29:0] d10x, d10y, d20x, d20y, d30x, d30y;
  logic signed [29:0] d32x, d32y, d31x, d31y;
  logic signed [29:0] inx, iny, outx, outy;
  logic signed [13:0] ix0, iy0, ix1, iy1, ix2, iy2, ix3, iy3;

  assign d10x = 30'(p1_x) - 30'(p0_x);
  assign d10y = 30'(p1_y) - 30'(p0_y);
  assign d20x = 30'(p2_x) - 30'(p0_x);
  assign d20y = 30'(p2_y) - 30'(p0_y);
  assign d30x = 30'(p3_x) - 30'(p0_x);
  assign d30y = 30'(p3_y) - 30'(p0_y);
  assign d32x = 30'(p3_x) - 30'(p2_x);
  assign d32y = 30'(p3_y) - 30'(p2_y);
  assign d31x = 30'(p3_x) - 30'(p1_x);
  assign d31y = 30'(p3_y) - 30'(p1_y);

  always_comb begin
    inx = d10x;
    iny = d10y;
    if (d10x == 0 && d10y == 0) begin
      inx = d20x;
      iny = d20y;
      if (d20x == 0 && d20y == 0) begin
        inx = d30x;
        iny = d30y;
      end
    end
    outx = d32x;
    outy = d32y;
    if (d32x == 0 && d32y == 0) begin
      outx = d31x;
      outy = d31y;
      if (d31x == 0 && d31y == 0) begin
        outx = d30x;
        outy = d30y;
      end
    end
  end

  assign ix0 = ipart(p0_x);
  assign iy0 = ipart(p0_y);
  assign ix1 = ipart(p1_x);
  assign iy1 = ipart(p1_y);
  assign ix2 = ipart(p2_x);
  assign iy2 = ipart(p2_y);
  assign ix3 = ipart(p3_x);
  assign iy3 = ipart(p3_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    v_in      <= prep(inx, iny);
    v_out     <= prep(outx, outy);
    idiff.e1x <= ix1 - ix0;
    idiff.e1y <= iy1 - iy0;
    idiff.e2x <= ix2 - ix1;
    idiff.e2y <= iy2 - iy1;
    idiff.e3x <= ix3 - ix2;
    idiff.e3y <= iy3 - iy2;
  end

endmodule

// ===== sv/bta_cordic.sv =====
module bta_cordic (
  input  logic                clk,
  input  logic                rst,
  input  logic                vld_in,
  input  bta_pkg::vec_t       v,
  output logic                vld_out,
  output logic signed [29:0]  z_out,
  output bta_pkg::dir_t       code_out
);
  import bta_pkg::*;

  logic signed [31:0] x    [0:ANGLE_STEPS-1];
  logic signed [31:0] y    [0:ANGLE_STEPS-1];
  logic signed [29:0] z    [0:ANGLE_STEPS];
  dir_t               code [0:ANGLE_STEPS];
  logic               vld  [0:ANGLE_STEPS];

  assign x[0]    = v.x;
  assign y[0]    = v.y;
  assign z[0]    = v.z;
  assign code[0] = v.code;
  assign vld[0]  = vld_in;

  // one vectoring step per register stage
  for (genvar i = 0; i < ANGLE_STEPS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      code[i+1] <= code[i];
      if (y[i] > 0) begin
        z[i+1] <= z[i] + $signed({3'b000, ATAN_TABLE[i]});
      end else begin
        z[i+1] <= z[i] - $signed({3'b000, ATAN_TABLE[i]});
      end
    end

    if (i < ANGLE_STEPS - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (y[i] > 0) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
        end
      end
    end
  end

  assign vld_out  = vld[ANGLE_STEPS];
  assign z_out    = z[ANGLE_STEPS];
  assign code_out = code[ANGLE_STEPS];

endmodule

// ===== sv/bta_cross.sv =====
module bta_cross (
  input  logic             clk,
  input  bta_pkg::idiff_t  idiff,
  output bta_pkg::cls_t    cls
);
  import bta_pkg::*;

  logic signed [27:0] p_a1, p_a2, p_b1, p_b2, p_c1, p_c2;
  logic signed [27:0] a, b, c;
  logic [26:0] ma, mb, mc;
  cls_t        pre3, pre4, pre5, cls6;
  logic [27:0] bb_ll, ac_ll;
  logic [26:0] bb_lh, ac_lh, ac_hl;
  logic [25:0] bb_hh, ac_hh;
  logic [53:0] bb;
  logic [55:0] ac4;
  cls_t        dly [0:CLASS_DLY-1];

  logic        az, bz, cz, an, bn, cn, ab_eq, cb_eq;
  cls_t        pre_next;
  logic [27:0] ma_w, mb_w, mc_w;

  // stage 1: six products
  always_ff @(posedge clk) begin
    p_a1 <= idiff.e1x * idiff.e2y;
    p_a2 <= idiff.e2x * idiff.e1y;
    p_b1 <= idiff.e1x * idiff.e3y;
    p_b2 <= idiff.e1y * idiff.e3x;
    p_c1 <= idiff.e2x * idiff.e3y;
    p_c2 <= idiff.e3x * idiff.e2y;
  end

  // stage 2: cross products
  always_ff @(posedge clk) begin
    a <= p_a1 - p_a2;
    b <= p_b1 - p_b2;
    c <= p_c1 - p_c2;
  end

  // stage 3: sign tests
  always_comb begin
    az = (a == 0);
    bz = (b == 0);
    cz = (c == 0);
    an = a[27];
    bn = b[27];
    cn = c[27];
    ab_eq = (az && bz) || (!az && !bz && an == bn);
    cb_eq = (cz && bz) || (!cz && !bz && cn == bn);
    if (az && cz) begin
      pre_next = bz ? CL_ZERO : CL_RAW;
    end else if (az || cz) begin
      pre_next = (ab_eq || cb_eq) ? CL_WRAP : CL_RAW;
    end else if (an != cn) begin
      pre_next = CL_WRAP;
    end else if (an == bn && !bz) begin
      pre_next = CL_WRAP;
    end else begin
      pre_next = CL_CMP;
    end
    ma_w = an ? -a : a;
    mb_w = bn ? -b : b;
    mc_w = cn ? -c : c;
  end

  always_ff @(posedge clk) begin
    pre3 <= pre_next;
    ma   <= ma_w[26:0];
    mb   <= mb_w[26:0];
    mc   <= mc_w[26:0];
  end

  // stage 4: partial products of b*b and a*c
  always_ff @(posedge clk) begin
    pre4  <= pre3;
    bb_ll <= mb[13:0] * mb[13:0];
    bb_lh <= 27'(mb[13:0] * mb[26:14]);
    bb_hh <= mb[26:14] * mb[26:14];
    ac_ll <= ma[13:0] * mc[13:0];
    ac_lh <= 27'(ma[13:0] * mc[26:14]);
    ac_hl <= 27'(ma[26:14] * mc[13:0]);
    ac_hh <= ma[26:14] * mc[26:14];
  end

  // stage 5: sum partials
  always_ff @(posedge clk) begin
    pre5 <= pre4;
    bb   <= (54'(bb_hh) << 28) + (54'(bb_lh) << 15) + 54'(bb_ll);
    ac4  <= ((56'(ac_hh) << 28) + ((56'(ac_lh) + 56'(ac_hl)) << 14) + 56'(ac_ll)) << 2;
  end

  // stage 6: resolve the discriminant compare
  always_ff @(posedge clk) begin
    if (pre5 == CL_CMP) begin
      if (56'(bb) == ac4) begin
        cls6 <= CL_CUSP;
      end else if (56'(bb) < ac4) begin
        cls6 <= CL_LOOP;
      end else begin
        cls6 <= CL_WRAP;
      end
    end else begin
      cls6 <= pre5;
    end
  end

  // hold the class until the angles catch up
  always_ff @(posedge clk) begin
    dly[0] <= cls6;
    for (int k = 1; k < CLASS_DLY; k++) begin
      dly[k] <= dly[k-1];
    end
  end

  assign cls = dly[CLASS_DLY-1];

endmodule

// ===== sv/bta_turn.sv =====
module bta_turn (
  input  logic                clk,
  input  logic                rst,
  input  logic                vld_in,
  input  logic signed [29:0]  z_in,
  input  bta_pkg::dir_t       code_in,
  input  logic signed [29:0]  z_out,
  input  bta_pkg::dir_t       code_out,
  input  bta_pkg::cls_t       cls,
  output logic                done,
  output logic signed [29:0]  turn_angle,
  output logic                cusp
);
  import bta_pkg::*;

  function automatic logic signed [29:0] final_angle(input dir_t code,
                                                      input logic signed [29:0] z);
    logic signed [29:0] r;
    case (code)
      DIR_ZERO: r = '0;
      DIR_HALF: r = DEG_180;
      DIR_UP:   r = DEG_90;
      DIR_DOWN: r = -DEG_90;
      default: begin
        if (z > DEG_180) begin
          r = z - DEG_360;
        end else if (z <= -DEG_180) begin
          r = z + DEG_360;
        end else begin
          r = z;
        end
      end
    endcase
    return r;
  endfunction

  logic signed [29:0] ang_in, ang_out;
  logic signed [9:0]  deg_in, deg_out, r, t;
  cls_t               cls1;
  logic               vld1;

  assign ang_in  = final_angle(code_in, z_in);
  assign ang_out = final_angle(code_out, z_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      done <= 1'b0;
    end else begin
      vld1 <= vld_in;
      done <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    deg_in  <= ang_in[29:20];
    deg_out <= ang_out[29:20];
    cls1    <= cls;
  end

  assign r = deg_out - deg_in;

  always_comb begin
    case (cls1)
      CL_ZERO, CL_CUSP: t = '0;
      CL_RAW: t = r;
      CL_LOOP: begin
        if (r <= 0 && r > -10'sd180) begin
          t = r + 10'sd360;
        end else if (r >= 0 && r < 10'sd180) begin
          t = r - 10'sd360;
        end else begin
          t = r;
        end
      end
      default: begin
        if (r < -10'sd180) begin
          t = r + 10'sd360;
        end else if (r > 10'sd180) begin
          t = r - 10'sd360;
        end else begin
          t = r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    turn_angle <= {t, 20'b0};
    cusp       <= (cls1 == CL_CUSP);
  end

endmodule

// ===== sv/bta_checker.sv =====
`include "assert_macros.svh"

module bta_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [29:0] turn_angle,
  input logic               cusp
);
  import bta_pkg::*;

  `BTA_ASSERT(a_latency, (start && !busy) |-> ##LATENCY done, "accepted item gave no result")
  `BTA_ASSERT(a_no_extra, done |-> $past(start && !busy, LATENCY), "result without an item")
  `BTA_ASSERT_NEVER(a_cusp_zero, done && cusp && turn_angle != 0, "cusp with nonzero turn")
  `BTA_ASSERT_NEVER(a_whole_deg, done && turn_angle[19:0] != 0, "turn not whole degrees")

endmodule

bind bezier_turning_angle bta_checker u_bta_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .turn_angle (turn_angle),
  .cusp       (cusp)
);

// ===== tb/sv/tb_bezier_turning_angle.sv =====
module tb_bezier_turning_angle;
  import bta_pkg::*;

  localparam longint ONE_DEG   = 64'sd1 << 20;
  localparam int     UNIT      = 65536;
  localparam int     MAX_CYC   = 400000;
  localparam int     N_RANDOM  = 1630;

  typedef struct {
    logic signed [28:0] c [8];   // p0_x, p0_y, p1_x, ... p3_y
    bit                 drain;   // hold until every pending result is back
  } seg_t;

  typedef struct {
    logic signed [29:0] angle;
    logic               cusp;
  } turn_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, cusp;
  logic signed [28:0] pt [8] = '{default: '0};
  logic signed [29:0] turn_angle;

  seg_t  segments [$];
  turn_t turns_due [$];
  int    mismatches = 0;
  int    cycles = 0;
  int    burst_left = 0;
  int    gap_left = 0;
  bit    taken = 1'b0;
  bit    loaded = 1'b0;
  seg_t  cur;

  always #5 clk = ~clk;

  bezier_turning_angle dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .p0_x(pt[0]), .p0_y(pt[1]), .p1_x(pt[2]), .p1_y(pt[3]),
    .p2_x(pt[4]), .p2_y(pt[5]), .p3_x(pt[6]), .p3_y(pt[7]),
    .done(done), .turn_angle(turn_angle), .cusp(cusp)
  );

  // Direction of (dx,dy) in 2^-20 degree, in (-180,180].
  function automatic longint heading(longint dx, longint dy);
    longint x, y, z, t, xs, ys;
    x = dx; y = dy; z = 0;
    if (dy == 0) return (dx < 0) ? 180 * ONE_DEG : 0;
    if (dx == 0) return (dy > 0) ? 90 * ONE_DEG : -90 * ONE_DEG;
    // fold the left half plane into the right one
    if (x < 0) begin
      t = x;
      if (y > 0) begin
        x = y; y = -t; z = 90 * ONE_DEG;
      end else begin
        x = -y; y = t; z = -90 * ONE_DEG;
      end
    end
    for (int i = 0; i < ANGLE_STEPS && i < TABLE_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(ATAN_TABLE[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(ATAN_TABLE[i]);
      end
    end
    if (z > 180 * ONE_DEG) z -= 360 * ONE_DEG;
    else if (z <= -180 * ONE_DEG) z += 360 * ONE_DEG;
    return z;
  endfunction

  function automatic longint wrap_turn(longint r);
    if (r < -180) return r + 360;
    if (r > 180) return r - 360;
    return r;
  endfunction

  function automatic int sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic turn_t net_turn(logic signed [28:0] c [8]);
    longint px [4], py [4], ix [4], iy [4];
    longint dx, dy, d_in, d_out, r, a, b, cc, tr;
    turn_t res;
    res.cusp = 1'b0;
    for (int k = 0; k < 4; k++) begin
      px[k] = c[2*k];
      py[k] = c[2*k+1];
      ix[k] = px[k] / UNIT;   // truncates toward zero
      iy[k] = py[k] / UNIT;
    end
    // entry direction with fallbacks for coincident points
    dx = px[1] - px[0]; dy = py[1] - py[0];
    if (dx == 0 && dy == 0) begin dx = px[2] - px[0]; dy = py[2] - py[0]; end
    if (dx == 0 && dy == 0) begin dx = px[3] - px[0]; dy = py[3] - py[0]; end
    d_in = heading(dx, dy) >>> 20;
    // exit direction
    dx = px[3] - px[2]; dy = py[3] - py[2];
    if (dx == 0 && dy == 0) begin dx = px[3] - px[1]; dy = py[3] - py[1]; end
    if (dx == 0 && dy == 0) begin dx = px[3] - px[0]; dy = py[3] - py[0]; end
    d_out = heading(dx, dy) >>> 20;

    a  = (ix[1]-ix[0])*(iy[2]-iy[1]) - (ix[2]-ix[1])*(iy[1]-iy[0]);
    b  = (ix[1]-ix[0])*(iy[3]-iy[2]) - (iy[1]-iy[0])*(ix[3]-ix[2]);
    cc = (ix[2]-ix[1])*(iy[3]-iy[2]) - (ix[3]-ix[2])*(iy[2]-iy[1]);

    r = d_out - d_in;
    if (a == 0 && cc == 0) tr = (b == 0) ? 0 : r;
    else if (a == 0 || cc == 0)
      tr = (sign_of(b) == sign_of(a) || sign_of(b) == sign_of(cc)) ? wrap_turn(r) : r;
    else if (sign_of(a) * sign_of(cc) < 0) tr = wrap_turn(r);
    else if (sign_of(a) == sign_of(b)) tr = wrap_turn(r);
    else if (b * b == 4 * a * cc) begin
      tr = 0;
      res.cusp = 1'b1;
    end else if (b * b < 4 * a * cc) begin
      // loop: the turn goes the long way round
      if (r <= 0 && r > -180) tr = r + 360;
      else if (r >= 0 && r < 180) tr = r - 360;
      else tr = r;
    end else tr = wrap_turn(r);
    res.angle = 30'(tr * ONE_DEG);
    return res;
  endfunction

  // Queue a segment given in whole units plus a raw fractional offset.
  task automatic add_seg(input int v [8], input int frac, input bit drain);
    seg_t s;
    for (int i = 0; i < 8; i++) s.c[i] = 29'(v[i] * UNIT + frac);
    s.drain = drain;
    segments.push_back(s);
  endtask

  task automatic add_raw(input logic signed [28:0] v [8]);
    seg_t s;
    s.c = v;
    s.drain = 1'b0;
    segments.push_back(s);
  endtask

  function automatic int grid(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Driver: present items at the falling edge, in bursts with gaps.
  always @(negedge clk) begin
    bit nxt;
    nxt = start;
    if (!rst) begin
      if (taken) begin
        loaded = 1'b0;
        nxt = 1'b0;
      end
      if (!loaded && segments.size() > 0) begin
        if (gap_left > 0) gap_left--;
        else if (segments[0].drain && turns_due.size() > 0) ;  // hold until drained
        else begin
          cur = segments.pop_front();
          loaded = 1'b1;
          for (int i = 0; i < 8; i++) pt[i] <= cur.c[i];
          nxt = 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
          end
        end
      end
    end
    start <= nxt;
  end

  // Monitor: check results and record accepted items at the rising edge.
  always @(posedge clk) begin
    turn_t want;
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      if (!rst && done) begin
        if (turns_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: turn_angle=%0d cusp=%0b", turn_angle, cusp);
        end else begin
          want = turns_due.pop_front();
          if (turn_angle !== want.angle || cusp !== want.cusp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: turn_angle exp %0d got %0d, cusp exp %0b got %0b",
                       want.angle, turn_angle, want.cusp, cusp);
          end
        end
      end
      taken = !rst && start && !busy;
      if (taken) turns_due.push_back(net_turn(pt));
    end
  end

  initial begin
    int v [8];
    logic signed [28:0] raw [8];
    int kind, span, frac;

    // Directed: degenerate, axis, coincident and classification corners.
    v = '{0, 0, 0, 0, 0, 0, 0, 0};          add_seg(v, 0, 0);
    v = '{0, 0, 1, 0, 2, 0, 3, 0};          add_seg(v, 0, 0);  // straight right
    v = '{3, 0, 2, 0, 1, 0, 0, 0};          add_seg(v, 0, 0);  // straight left
    v = '{0, 0, 0, 1, 0, 2, 0, 3};          add_seg(v, 0, 0);  // up
    v = '{0, 0, 0, -1, 0, -2, 0, -3};       add_seg(v, 0, 0);  // down
    v = '{0, 0, 0, 0, 2, 1, 3, 3};          add_seg(v, 0, 0);  // P1 on P0
    v = '{1, 1, 1, 1, 1, 1, -2, 5};         add_seg(v, 0, 0);  // P0=P1=P2
    v = '{0, 0, 1, 2, 4, -1, 4, -1};        add_seg(v, 0, 0);  // P3 on P2
    v = '{0, 0, 3, 3, 3, 3, 3, 3};          add_seg(v, 0, 0);  // P1=P2=P3
    v = '{0, 0, 1, 0, 0, 1, 1, -1};         add_seg(v, 0, 0);  // cusp
    v = '{0, 0, 1, 0, 1, 1, 0, 1};          add_seg(v, 0, 0);  // loop branch
    v = '{0, 0, 1, 0, 1, 1, 2, 1};          add_seg(v, 0, 0);  // inflection
    v = '{0, 0, 2, 2, 4, 0, 6, 2};          add_seg(v, 0, 0);
    v = '{0, 0, -1, 1, -2, -1, -3, 0};      add_seg(v, 0, 0);
    v = '{0, 0, 1, -1, -1, -1, -1, 1};      add_seg(v, 0, 1);  // wait for drain
    v = '{0, 0, 0, 0, 0, 0, 0, 0};          add_seg(v, -1, 0);
    raw = '{29'sh0FFFFFFF, 29'sh10000000, 29'sh10000000, 29'sh0FFFFFFF,
            29'sh0FFFFFFF, 29'sh0FFFFFFF, 29'sh10000000, 29'sh10000000};
    add_raw(raw);
    raw = '{29'sh10000000, 29'sh10000000, 29'sh0FFFFFFF, 29'sh0FFFFFFF,
            29'sh10000000, 29'sh0FFFFFFF, 29'sh0FFFFFFF, 29'sh10000000};
    add_raw(raw);
    raw = '{29'sd1, 29'sd0, 29'sd0, 29'sd1, -29'sd1, 29'sd0, 29'sd0, -29'sd1};
    add_raw(raw);  // fractions only: all integer parts zero
    raw = '{-29'sd65535, 29'sd65535, 29'sd65536, -29'sd65536,
            29'sd131071, 29'sd3, -29'sd131072, 29'sd7};
    add_raw(raw);  // truncation toward zero around the unit boundary

    // Random: small and large grids and raw points; the small grids aim to reach every classification branch.
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        span = (kind <= 3) ? 3 : 2000;
        for (int i = 0; i < 8; i++) v[i] = grid(span);
        frac = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 65535);
        if (kind == 0) begin  // force coincidences
          if ($urandom_range(0, 1)) begin v[2] = v[0]; v[3] = v[1]; end
          if ($urandom_range(0, 1)) begin v[4] = v[2]; v[5] = v[3]; end
          if ($urandom_range(0, 1)) begin v[6] = v[4]; v[7] = v[5]; end
        end
        add_seg(v, frac, (n % 400) == 399);
      end else begin
        for (int i = 0; i < 8; i++) begin
          raw[i] = 29'($urandom);
          if (kind == 9) raw[i] = 29'($urandom_range(0, 8)) - 29'sd4;
        end
        add_raw(raw);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    wait (segments.size() == 0 && !loaded && turns_due.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatches == 0 && turns_due.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
